// ===== hw/rtl/tdbl_pkg.sv =====
`default_nettype none

package tdbl_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned NODE_W     = 10;
  localparam int unsigned DEPTH_W    = 10;
  localparam int unsigned DIST_W     = 11;
  localparam int unsigned ENTRY_W    = NODE_W + 1;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // An ancestor entry carries a valid flag above the node number.
  localparam int unsigned ENTRY_VALID_BIT = NODE_W;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;
  localparam logic [DIST_W-1:0]  DIST_NONE = 11'd2047;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 11'd2046;

  // Item kinds, carried on tuser.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [15:0] {
    ST_IDLE    = 16'b0000_0000_0000_0001,
    ST_LD_ROOT = 16'b0000_0000_0000_0010,
    ST_LD_DEP  = 16'b0000_0000_0000_0100,
    ST_LD_RD   = 16'b0000_0000_0000_1000,
    ST_LD_WR   = 16'b0000_0000_0001_0000,
    ST_Q_DA    = 16'b0000_0000_0010_0000,
    ST_Q_DB    = 16'b0000_0000_0100_0000,
    ST_Q_LIFT  = 16'b0000_0000_1000_0000,
    ST_Q_LWAIT = 16'b0000_0001_0000_0000,
    ST_Q_CHK   = 16'b0000_0010_0000_0000,
    ST_Q_UP    = 16'b0000_0100_0000_0000,
    ST_Q_UPW   = 16'b0000_1000_0000_0000,
    ST_Q_PAR   = 16'b0001_0000_0000_0000,
    ST_Q_PARW  = 16'b0010_0000_0000_0000,
    ST_Q_DANC  = 16'b0100_0000_0000_0000,
    ST_Q_FIN   = 16'b1000_0000_0000_0000
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/tree_distance_binary_lifting_top.sv =====
`default_nettype none

// Lowest common ancestor and tree distance by binary lifting. Every input item carries a
// kind on tuser. A load item (kind 0) names a node and its parent, or marks the node as a
// root. Loads must come in preorder, so that a parent is always loaded before its children.
// A load produces no result item. A query item (kind 1) names two nodes and produces exactly
// one result item: the number of edges between the nodes and their lowest common ancestor.
// Nodes in different trees, or a node at or above MAX_NODES, give a distance of all ones and
// an ancestor of zero. Only one item is in progress at a time, and tready stays low until
// that item is finished. All table traffic goes through one ancestor memory and one depth
// memory, each with registered reads. A root load writes every level without reading
// either memory. For each level past a missing ancestor, a load writes an empty entry
// without a memory read. Each set bit of the depth difference costs a query one read of
// the ancestor memory, and a second pass runs only when lifting the deeper node does not
// land on the other one. A query that names a node at or above MAX_NODES goes straight
// to the output. A finished result waits in an output register, and the next item is
// accepted while it waits; a query that finishes while the output register is still
// full holds until that register empties. The memories need no clearing pass after reset.

module tree_distance_binary_lifting_top #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned LIFT_LEVELS = 10
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // node_a [9:0], node_b [19:10], is_root [20], zero [23:21]
  input  wire logic [tdbl_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // kind [0]
  input  wire logic                               s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tree_distance [10:0], common_ancestor [20:11], zero [23:21]
  output logic [tdbl_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o
);

  localparam int unsigned NW = tdbl_pkg::NODE_W;
  localparam int unsigned EW = tdbl_pkg::ENTRY_W;
  localparam int unsigned DW = tdbl_pkg::DEPTH_W;
  localparam int unsigned TW = tdbl_pkg::DIST_W;
  localparam int unsigned VB = tdbl_pkg::ENTRY_VALID_BIT;

  // Node address width and jump level width; the ancestor memory is indexed by
  // the node in the upper bits and the jump level in the lower bits.
  localparam int unsigned AW       = $clog2(MAX_NODES);
  localparam int unsigned LW       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int unsigned ANC_SIZE = 2 ** (AW + LW);

  localparam logic [LW-1:0] LVL_LAST = LW'(LIFT_LEVELS - 1);

  // Storage. Neither memory is reset; preorder loading guarantees that every
  // entry is written before it is read.
  logic [EW-1:0] anc_mem [ANC_SIZE];
  logic [DW-1:0] dep_mem [MAX_NODES];

  // Memory ports.
  logic               anc_we;
  logic [AW+LW-1:0]   anc_waddr;
  logic [EW-1:0]      anc_wdata;
  logic               anc_re_a;
  logic [AW+LW-1:0]   anc_raddr_a;
  logic [EW-1:0]      anc_rdata_a_q;
  logic               anc_re_b;
  logic [AW+LW-1:0]   anc_raddr_b;
  logic [EW-1:0]      anc_rdata_b_q;
  logic               dep_we;
  logic [AW-1:0]      dep_waddr;
  logic [DW-1:0]      dep_wdata;
  logic               dep_re;
  logic [AW-1:0]      dep_raddr;
  logic [DW-1:0]      dep_rdata_q;

  // Sequencer and working registers.
  tdbl_pkg::state_e state_q, state_d;
  logic [LW-1:0]    lvl_q, lvl_d;
  logic [NW-1:0]    a_q, a_d;
  logic [NW-1:0]    b_q, b_d;
  logic [NW-1:0]    u_q, u_d;
  logic [NW-1:0]    v_q, v_d;
  logic [EW-1:0]    prev_q, prev_d;
  logic [DW-1:0]    diff_q, diff_d;
  logic [DW-1:0]    da_q, da_d;
  logic [TW-1:0]    sum_q, sum_d;
  logic [TW-1:0]    dist_q, dist_d;
  logic [NW-1:0]    anc_q, anc_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  logic [TW-1:0] out_dist_q, out_dist_d;
  logic [NW-1:0] out_anc_q, out_anc_d;

  // Input fields.
  logic          in_kind;
  logic [NW-1:0] in_a;
  logic [NW-1:0] in_b;
  logic          in_root;
  logic          in_a_ok;
  logic          in_b_ok;
  logic          in_accept;

  logic          lvl_is_last;
  logic [TW:0]   dist_raw;
  logic [DW-1:0] dep_inc;

  assign in_kind   = s_axis_tuser_i;
  assign in_a      = s_axis_tdata_i[NW-1:0];
  assign in_b      = s_axis_tdata_i[2*NW-1:NW];
  assign in_root   = s_axis_tdata_i[2*NW];
  assign in_a_ok   = 32'(in_a) < 32'(MAX_NODES);
  assign in_b_ok   = 32'(in_b) < 32'(MAX_NODES);

  assign s_axis_tready_o = (state_q == tdbl_pkg::ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(tdbl_pkg::OUT_DATA_W - TW - NW)'(0), out_anc_q, out_dist_q};

  assign lvl_is_last = (lvl_q == LVL_LAST);

  // The new node sits one level below its parent; the depth saturates.
  assign dep_inc = (dep_rdata_q == tdbl_pkg::DEPTH_MAX) ? tdbl_pkg::DEPTH_MAX
                                                        : dep_rdata_q + DW'(1);

  // Distance is depth(a) + depth(b) - 2 * depth(ancestor), as a signed value.
  assign dist_raw = {1'b0, sum_q} - {1'b0, dep_rdata_q, 1'b0};

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    a_d         = a_q;
    b_d         = b_q;
    u_d         = u_q;
    v_d         = v_q;
    prev_d      = prev_q;
    diff_d      = diff_q;
    da_d        = da_q;
    sum_d       = sum_q;
    dist_d      = dist_q;
    anc_d       = anc_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_dist_d  = out_dist_q;
    out_anc_d   = out_anc_q;

    anc_we      = 1'b0;
    anc_waddr   = {AW'(a_q), lvl_q};
    anc_wdata   = '0;
    anc_re_a    = 1'b0;
    anc_raddr_a = {AW'(u_q), lvl_q};
    anc_re_b    = 1'b0;
    anc_raddr_b = {AW'(v_q), lvl_q};
    dep_we      = 1'b0;
    dep_waddr   = AW'(a_q);
    dep_wdata   = '0;
    dep_re      = 1'b0;
    dep_raddr   = AW'(in_b);

    unique case (state_q)
      tdbl_pkg::ST_IDLE: begin
        lvl_d = '0;
        if (in_accept) begin
          a_d = in_a;
          b_d = in_b;
          if (in_kind == tdbl_pkg::KIND_LOAD) begin
            if (in_a_ok && in_root) begin
              state_d = tdbl_pkg::ST_LD_ROOT;
            end else if (in_a_ok && in_b_ok) begin
              dep_re    = 1'b1;
              dep_raddr = AW'(in_b);
              state_d   = tdbl_pkg::ST_LD_DEP;
            end
          end else begin
            if (in_a_ok && in_b_ok) begin
              dep_re    = 1'b1;
              dep_raddr = AW'(in_a);
              state_d   = tdbl_pkg::ST_Q_DA;
            end else begin
              dist_d  = tdbl_pkg::DIST_NONE;
              anc_d   = '0;
              state_d = tdbl_pkg::ST_Q_FIN;
            end
          end
        end
      end

      // A root gets depth zero and no ancestor at any level.
      tdbl_pkg::ST_LD_ROOT: begin
        dep_we    = 1'b1;
        dep_wdata = '0;
        anc_we    = 1'b1;
        anc_wdata = '0;
        if (lvl_is_last) begin
          state_d = tdbl_pkg::ST_IDLE;
        end else begin
          lvl_d = lvl_q + LW'(1);
        end
      end

      tdbl_pkg::ST_LD_DEP: begin
        dep_we    = 1'b1;
        dep_wdata = dep_inc;
        anc_we    = 1'b1;
        anc_wdata = {1'b1, b_q};
        prev_d    = {1'b1, b_q};
        if (lvl_is_last) begin
          state_d = tdbl_pkg::ST_IDLE;
        end else begin
          lvl_d   = lvl_q + LW'(1);
          state_d = tdbl_pkg::ST_LD_RD;
        end
      end

      // Level i is the level i-1 entry of the level i-1 ancestor.
      tdbl_pkg::ST_LD_RD: begin
        if (prev_q[VB]) begin
          anc_re_a    = 1'b1;
          anc_raddr_a = {AW'(prev_q[NW-1:0]), lvl_q - LW'(1)};
          state_d     = tdbl_pkg::ST_LD_WR;
        end else begin
          anc_we    = 1'b1;
          anc_wdata = '0;
          if (lvl_is_last) begin
            state_d = tdbl_pkg::ST_IDLE;
          end else begin
            lvl_d = lvl_q + LW'(1);
          end
        end
      end

      tdbl_pkg::ST_LD_WR: begin
        anc_we    = 1'b1;
        anc_wdata = anc_rdata_a_q;
        prev_d    = anc_rdata_a_q;
        if (lvl_is_last) begin
          state_d = tdbl_pkg::ST_IDLE;
        end else begin
          lvl_d   = lvl_q + LW'(1);
          state_d = tdbl_pkg::ST_LD_RD;
        end
      end

      tdbl_pkg::ST_Q_DA: begin
        da_d      = dep_rdata_q;
        dep_re    = 1'b1;
        dep_raddr = AW'(b_q);
        state_d   = tdbl_pkg::ST_Q_DB;
      end

      // The deeper node becomes u; the difference drives the first pass.
      tdbl_pkg::ST_Q_DB: begin
        sum_d = {1'b0, da_q} + {1'b0, dep_rdata_q};
        if (da_q < dep_rdata_q) begin
          u_d    = b_q;
          v_d    = a_q;
          diff_d = dep_rdata_q - da_q;
        end else begin
          u_d    = a_q;
          v_d    = b_q;
          diff_d = da_q - dep_rdata_q;
        end
        lvl_d   = '0;
        state_d = tdbl_pkg::ST_Q_LIFT;
      end

      tdbl_pkg::ST_Q_LIFT: begin
        if (diff_q[0]) begin
          anc_re_a = 1'b1;
          state_d  = tdbl_pkg::ST_Q_LWAIT;
        end else begin
          diff_d = diff_q >> 1;
          if (lvl_is_last) begin
            state_d = tdbl_pkg::ST_Q_CHK;
          end else begin
            lvl_d = lvl_q + LW'(1);
          end
        end
      end

      tdbl_pkg::ST_Q_LWAIT: begin
        if (anc_rdata_a_q[VB]) begin
          u_d = anc_rdata_a_q[NW-1:0];
        end
        diff_d = diff_q >> 1;
        if (lvl_is_last) begin
          state_d = tdbl_pkg::ST_Q_CHK;
        end else begin
          lvl_d   = lvl_q + LW'(1);
          state_d = tdbl_pkg::ST_Q_LIFT;
        end
      end

      tdbl_pkg::ST_Q_CHK: begin
        if (u_q == v_q) begin
          anc_d     = u_q;
          dep_re    = 1'b1;
          dep_raddr = AW'(u_q);
          state_d   = tdbl_pkg::ST_Q_DANC;
        end else begin
          lvl_d   = LVL_LAST;
          state_d = tdbl_pkg::ST_Q_UP;
        end
      end

      // Second pass, from the widest jump down: both nodes move while their
      // ancestors at that level still differ and both exist.
      tdbl_pkg::ST_Q_UP: begin
        anc_re_a = 1'b1;
        anc_re_b = 1'b1;
        state_d  = tdbl_pkg::ST_Q_UPW;
      end

      tdbl_pkg::ST_Q_UPW: begin
        if ((anc_rdata_a_q != anc_rdata_b_q) && anc_rdata_a_q[VB] && anc_rdata_b_q[VB]) begin
          u_d = anc_rdata_a_q[NW-1:0];
          v_d = anc_rdata_b_q[NW-1:0];
        end
        if (lvl_q == '0) begin
          state_d = tdbl_pkg::ST_Q_PAR;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = tdbl_pkg::ST_Q_UP;
        end
      end

      tdbl_pkg::ST_Q_PAR: begin
        anc_re_a    = 1'b1;
        anc_raddr_a = {AW'(u_q), LW'(0)};
        state_d     = tdbl_pkg::ST_Q_PARW;
      end

      // The parent of u is the common ancestor; without one the trees differ.
      tdbl_pkg::ST_Q_PARW: begin
        if (anc_rdata_a_q[VB]) begin
          anc_d     = anc_rdata_a_q[NW-1:0];
          dep_re    = 1'b1;
          dep_raddr = AW'(anc_rdata_a_q[NW-1:0]);
          state_d   = tdbl_pkg::ST_Q_DANC;
        end else begin
          dist_d  = tdbl_pkg::DIST_NONE;
          anc_d   = '0;
          state_d = tdbl_pkg::ST_Q_FIN;
        end
      end

      tdbl_pkg::ST_Q_DANC: begin
        if (dist_raw[TW]) begin
          dist_d = '0;
        end else if (dist_raw[TW-1:0] > tdbl_pkg::DIST_MAX) begin
          dist_d = tdbl_pkg::DIST_MAX;
        end else begin
          dist_d = dist_raw[TW-1:0];
        end
        state_d = tdbl_pkg::ST_Q_FIN;
      end

      // Hand the result over once the output register is free.
      tdbl_pkg::ST_Q_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_dist_d  = dist_q;
          out_anc_d   = anc_q;
          state_d     = tdbl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tdbl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdbl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q      <= lvl_d;
    a_q        <= a_d;
    b_q        <= b_d;
    u_q        <= u_d;
    v_q        <= v_d;
    prev_q     <= prev_d;
    diff_q     <= diff_d;
    da_q       <= da_d;
    sum_q      <= sum_d;
    dist_q     <= dist_d;
    anc_q      <= anc_d;
    out_dist_q <= out_dist_d;
    out_anc_q  <= out_anc_d;
  end

  // Ancestor memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (anc_we) begin
      anc_mem[anc_waddr] <= anc_wdata;
    end
    if (anc_re_a) begin
      anc_rdata_a_q <= anc_mem[anc_raddr_a];
    end
    if (anc_re_b) begin
      anc_rdata_b_q <= anc_mem[anc_raddr_b];
    end
  end

  // Depth memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    if (dep_re) begin
      dep_rdata_q <= dep_mem[dep_raddr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

localparam int unsigned TREE_NODES  = 1024;
localparam int unsigned TREE_LEVELS = 10;

typedef struct packed {
  logic [tdbl_pkg::DIST_W-1:0] distance;
  logic [tdbl_pkg::NODE_W-1:0] ancestor;
} lca_answer_t;

// Shadow copy of the ancestor and depth tables, plus the queue of answers that
// the block still owes for queries it has accepted.
class tree_query_checker;
  bit [tdbl_pkg::ENTRY_W-1:0] ancestors [TREE_NODES][TREE_LEVELS];
  bit [tdbl_pkg::DEPTH_W-1:0] depths [TREE_NODES];
  lca_answer_t                awaited_answers [$];
  int unsigned                errors;
  int unsigned                loads_seen;
  int unsigned                saturated_loads;
  int unsigned                queries_seen;
  int unsigned                apart_answers;
  int unsigned                clamped_answers;

  function void store_node(bit [9:0] node, bit [9:0] parent, bit root);
    bit [tdbl_pkg::ENTRY_W-1:0] prev;
    bit [31:0]                  d;
    loads_seen++;
    if (root) begin
      depths[node] = '0;
      for (int i = 0; i < TREE_LEVELS; i++) ancestors[node][i] = '0;
      return;
    end
    // The parent's depth is read before the node's own entry changes, which
    // matters when a node is loaded as its own parent.
    d = depths[parent] + 1;
    if (d > tdbl_pkg::DEPTH_MAX) begin
      depths[node] = tdbl_pkg::DEPTH_MAX;
      saturated_loads++;
    end else begin
      depths[node] = d[9:0];
    end
    ancestors[node][0] = {1'b1, parent};
    for (int i = 1; i < TREE_LEVELS; i++) begin
      prev = ancestors[node][i-1];
      ancestors[node][i] = prev[tdbl_pkg::ENTRY_VALID_BIT] ? ancestors[prev[9:0]][i-1] : '0;
    end
  endfunction

  function bit lowest_common_ancestor(bit [9:0] u_in, bit [9:0] v_in, output bit [9:0] anc);
    bit [9:0]                   u;
    bit [9:0]                   v;
    bit [9:0]                   t;
    bit [9:0]                   diff;
    bit [tdbl_pkg::ENTRY_W-1:0] eu;
    bit [tdbl_pkg::ENTRY_W-1:0] ev;
    u   = u_in;
    v   = v_in;
    anc = '0;
    if (depths[u] < depths[v]) begin
      diff = depths[v] - depths[u];
      t = u;
      u = v;
      v = t;
    end else begin
      diff = depths[u] - depths[v];
    end
    // Bring the deeper node up to the other's depth; a missing jump stays put.
    for (int i = 0; i < TREE_LEVELS; i++) begin
      if (diff[i]) begin
        eu = ancestors[u][i];
        if (eu[tdbl_pkg::ENTRY_VALID_BIT]) u = eu[9:0];
      end
    end
    if (u == v) begin
      anc = u;
      return 1'b1;
    end
    for (int i = TREE_LEVELS - 1; i >= 0; i--) begin
      eu = ancestors[u][i];
      ev = ancestors[v][i];
      if (eu != ev && eu[tdbl_pkg::ENTRY_VALID_BIT] && ev[tdbl_pkg::ENTRY_VALID_BIT]) begin
        u = eu[9:0];
        v = ev[9:0];
      end
    end
    eu = ancestors[u][0];
    if (eu[tdbl_pkg::ENTRY_VALID_BIT]) begin
      anc = eu[9:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function lca_answer_t path_answer(bit [9:0] u, bit [9:0] v);
    lca_answer_t ans;
    bit [9:0]    anc;
    int          span;
    queries_seen++;
    if (!lowest_common_ancestor(u, v, anc)) begin
      apart_answers++;
      ans.distance = tdbl_pkg::DIST_NONE;
      ans.ancestor = '0;
      return ans;
    end
    span = int'(depths[u]) + int'(depths[v]) - 2 * int'(depths[anc]);
    if (span < 0 || span > int'(tdbl_pkg::DIST_MAX)) clamped_answers++;
    if (span < 0) span = 0;
    if (span > int'(tdbl_pkg::DIST_MAX)) span = int'(tdbl_pkg::DIST_MAX);
    ans.distance = span[10:0];
    ans.ancestor = anc;
    return ans;
  endfunction

  function void note_item(bit kind, bit [9:0] a, bit [9:0] b, bit root);
    if (kind == tdbl_pkg::KIND_LOAD) store_node(a, b, root);
    else awaited_answers = {awaited_answers, path_answer(a, b)};
  endfunction

  function void check_answer(logic [tdbl_pkg::OUT_DATA_W-1:0] data);
    lca_answer_t want;
    if (awaited_answers.size() == 0) begin
      errors++;
      if (errors <= 10) $display("answer %h arrived with no query outstanding", data);
      return;
    end
    want = awaited_answers.pop_front();
    if (data[10:0] !== want.distance || data[20:11] !== want.ancestor) begin
      errors++;
      if (errors <= 10) begin
        $display("wrong answer: distance exp %0d got %0d, ancestor exp %0d got %0d",
                 want.distance, data[10:0], want.ancestor, data[20:11]);
      end
    end
  endfunction
endclass

module tb_top;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid_i;
  logic                            s_axis_tready_o;
  logic [tdbl_pkg::IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                            s_axis_tuser_i;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i;
  logic [tdbl_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;

  tree_query_checker sb = new();

  bit          tx_burst;
  bit          rx_burst;
  bit          long_hold_done;
  int unsigned answers_taken;

  tree_distance_binary_lifting_top #(
    .MAX_NODES  (TREE_NODES),
    .LIFT_LEVELS(TREE_LEVELS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Offers one item after a random gap and holds it until the block takes it.
  // Valid stays high across back-to-back items.
  task automatic send_item(bit kind, bit [9:0] a, bit [9:0] b, bit root);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {3'b000, root, b, a};
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    sb.note_item(kind, a, b, root);
  endtask

  task automatic load_child(bit [9:0] node, bit [9:0] parent);
    send_item(tdbl_pkg::KIND_LOAD, node, parent, 1'b0);
  endtask

  task automatic load_root(bit [9:0] node);
    send_item(tdbl_pkg::KIND_LOAD, node, 10'($urandom), 1'b1);
  endtask

  task automatic ask(bit [9:0] u, bit [9:0] v);
    send_item(tdbl_pkg::KIND_QUERY, u, v, 1'($urandom));
  endtask

  // Stops offering items until every owed answer has been collected.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.awaited_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    load_root(10'd0);
    load_child(10'd1, 10'd0);
    load_child(10'd2, 10'd1);
    load_child(10'd3, 10'd1);
    load_child(10'd1023, 10'd0);
    send_item(tdbl_pkg::KIND_LOAD, 10'd5, 10'd1023, 1'b1);
    load_child(10'd6, 10'd5);
    ask(10'd2, 10'd3);
    ask(10'd1023, 10'd2);
    ask(10'd2, 10'd2);
    ask(10'd0, 10'd1023);
    // Nodes in two separate trees have no common ancestor.
    ask(10'd6, 10'd3);
    load_child(10'd682, 10'd1023);
    load_child(10'd341, 10'd682);
    ask(10'd341, 10'd3);
    // A node that names itself as parent gets a deeper depth while every jump
    // points back at itself, which later drives the distance below zero.
    load_child(10'd6, 10'd6);
    ask(10'd6, 10'd5);
    // Turning an inner node into a root leaves its children with stale rows.
    load_root(10'd1);
    ask(10'd2, 10'd1);
    ask(10'd2, 10'd0);
    ask(10'd1023, 10'd1023);
    ask(10'd341, 10'd682);
  endtask

  // One chain through every node in random order: depths run up to the limit,
  // every lifting level gets used, and every table entry ends up written.
  task automatic run_deep_chain();
    bit [9:0]    order [TREE_NODES];
    bit [9:0]    t;
    int unsigned j;
    for (int i = 0; i < TREE_NODES; i++) order[i] = i[9:0];
    for (int i = TREE_NODES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    load_root(order[0]);
    for (int i = 1; i < TREE_NODES; i++) begin
      load_child(order[i], order[i-1]);
      if (i % 8 == 0) ask(order[$urandom_range(0, i)], order[$urandom_range(0, i)]);
    end
    // Both of these push the depth past its maximum, so it saturates.
    load_child(order[TREE_NODES-1], order[TREE_NODES-1]);
    load_child(order[0], order[TREE_NODES-1]);
    repeat (40) begin
      ask(order[$urandom_range(0, TREE_NODES-1)], order[$urandom_range(0, TREE_NODES-1)]);
    end
  endtask

  // Builds fresh forests over the already written tables. Most items grow the
  // current forest or query it; the rest are stray loads and queries.
  task automatic run_forest_epochs(int unsigned total);
    bit [9:0]    grown [$];
    bit [9:0]    node;
    bit [9:0]    parent;
    int unsigned sent;
    int unsigned roll;
    int unsigned back;
    sent = 0;
    while (sent < total) begin
      grown.delete();
      repeat ($urandom_range(1, 3)) begin
        node = 10'($urandom);
        load_root(node);
        grown = {grown, node};
        sent++;
      end
      repeat ($urandom_range(30, 120)) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          // Favor the newest nodes as parents so that the trees grow deep.
          if ($urandom_range(0, 9) < 6) begin
            back = $urandom_range(0, (grown.size() > 3) ? 2 : grown.size() - 1);
            parent = grown[grown.size() - 1 - back];
          end else begin
            parent = grown[$urandom_range(0, grown.size() - 1)];
          end
          node = 10'($urandom);
          load_child(node, parent);
          grown = {grown, node};
        end else if (roll < 85) begin
          ask(grown[$urandom_range(0, grown.size() - 1)],
              grown[$urandom_range(0, grown.size() - 1)]);
        end else if (roll < 92) begin
          ask(10'($urandom), 10'($urandom));
        end else if (roll < 96) begin
          load_child(10'($urandom), 10'($urandom));
        end else if (roll < 98) begin
          node = grown[$urandom_range(0, grown.size() - 1)];
          load_child(node, node);
        end else begin
          load_root(10'($urandom));
        end
        sent++;
      end
    end
  endtask

  // Result side: random stalls per answer, runs without stalls, and one long
  // hold-off so that the block backs up and blocks new items.
  initial begin : answer_sink
    int unsigned stall;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && answers_taken >= 200) begin
        stall = 500;
        long_hold_done = 1'b1;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 4);
      end
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid_o !== 1'b1);
      sb.check_answer(m_axis_tdata_o);
      answers_taken++;
    end
  end

  initial begin : stimulus
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= tdbl_pkg::KIND_LOAD;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    wait_drained();
    run_deep_chain();
    wait_drained();
    run_forest_epochs(300);
    wait_drained();
    // A trailing load may still be writing its rows; give it time to finish.
    repeat (60) @(posedge clk_i);
    $display("Covered %0d loads (%0d with saturated depth) and %0d queries,",
             sb.loads_seen, sb.saturated_loads, sb.queries_seen);
    $display("with %0d answers across separate trees and %0d with a clamped distance.",
             sb.apart_answers, sb.clamped_answers);
    if (sb.errors == 0 && sb.awaited_answers.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d errors, %0d answers never arrived", sb.errors, sb.awaited_answers.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("timed out with %0d answers outstanding", sb.awaited_answers.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
